// ===== design/plnb_pkg.sv =====
// shared types and constants for the periodic lattice neighbor core
package plnb_pkg;

	localparam int MAX_RANK      = 4;
	localparam int SITE_W        = 32;
	localparam int EXT_W         = 9;
	localparam int RANK_W        = 3;
	localparam int AXIS_W        = 2;
	localparam int CFG_IDX_W     = 3;
	// product of all extents fits exactly, no saturation needed
	localparam int PROD_W        = EXT_W * MAX_RANK;
	// cycles for the trailing products to settle after a register write
	localparam int SETTLE_CYCLES = MAX_RANK + 2;
	localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANK = 3'd0,
		REG_EXT0 = 3'd1,
		REG_EXT1 = 3'd2,
		REG_EXT2 = 3'd3,
		REG_EXT3 = 3'd4
	} cfg_reg_e;

	typedef logic [PROD_W-1:0] prod_t;

	// derived lattice geometry, prod[k] is the product of extents k .. rank-1
	typedef struct packed {
		logic [RANK_W-1:0]     rank;
		prod_t [MAX_RANK:0]    prod;
		prod_t [MAX_RANK-1:0]  diff;
	} lat_cfg_t;

	// one query word as it moves along the remainder chain
	typedef struct packed {
		logic              valid;
		logic              invalid;
		logic              back;
		logic [AXIS_W-1:0] axis;
		logic [SITE_W-1:0] site;
		logic [SITE_W-1:0] rem;
	} item_t;

	typedef struct packed {
		logic              invalid;
		logic [SITE_W-1:0] neighbor;
	} result_t;

endpackage

// ===== design/plnb_cfg.sv =====
// configuration registers and trailing extent products
module plnb_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [plnb_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [plnb_pkg::EXT_W-1:0]            wr_data,
	output plnb_pkg::lat_cfg_t                    cfg,
	output logic                                  busy
);

	localparam int MUL_W = plnb_pkg::PROD_W + plnb_pkg::EXT_W;

	logic [plnb_pkg::RANK_W-1:0]                           rank_q;
	logic [plnb_pkg::MAX_RANK-1:0][plnb_pkg::EXT_W-1:0]    ext_q;
	plnb_pkg::prod_t [plnb_pkg::MAX_RANK-1:0]              prod_q;
	plnb_pkg::prod_t [plnb_pkg::MAX_RANK-1:0]              diff_q;
	plnb_pkg::prod_t [plnb_pkg::MAX_RANK:0]                prod_all;
	plnb_pkg::prod_t [plnb_pkg::MAX_RANK-1:0]              prod_next;
	logic [plnb_pkg::MAX_RANK-1:0][MUL_W-1:0]              mul_w;
	logic [plnb_pkg::SETTLE_W-1:0]                         settle_q;
	logic [plnb_pkg::RANK_W-1:0]                           rank_eff;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= plnb_pkg::RANK_W'(1);
			for (int k = 0; k < plnb_pkg::MAX_RANK; k++) begin
				ext_q[k] <= plnb_pkg::EXT_W'(1);
			end
		end else if (wr_en) begin
			unique case (plnb_pkg::cfg_reg_e'(wr_index))
				plnb_pkg::REG_RANK: rank_q   <= wr_data[plnb_pkg::RANK_W-1:0];
				plnb_pkg::REG_EXT0: ext_q[0] <= wr_data;
				plnb_pkg::REG_EXT1: ext_q[1] <= wr_data;
				plnb_pkg::REG_EXT2: ext_q[2] <= wr_data;
				plnb_pkg::REG_EXT3: ext_q[3] <= wr_data;
				default: ;
			endcase
		end
	end

	// rank saturates at the number of axes built
	assign rank_eff = (rank_q > plnb_pkg::RANK_W'(plnb_pkg::MAX_RANK)) ?
		plnb_pkg::RANK_W'(plnb_pkg::MAX_RANK) : rank_q;

	assign prod_all = {plnb_pkg::PROD_W'(1), prod_q};

	// one multiply per axis, each cell takes its upper neighbor's product
	always_comb begin
		for (int k = 0; k < plnb_pkg::MAX_RANK; k++) begin
			mul_w[k] = MUL_W'(ext_q[k]) * MUL_W'(prod_all[k+1]);
			prod_next[k] = (plnb_pkg::RANK_W'(k) < rank_eff) ?
				mul_w[k][plnb_pkg::PROD_W-1:0] : plnb_pkg::PROD_W'(1);
		end
	end

	// products ripple down one axis per cycle until stable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < plnb_pkg::MAX_RANK; k++) begin
				prod_q[k] <= plnb_pkg::PROD_W'(1);
				diff_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < plnb_pkg::MAX_RANK; k++) begin
				prod_q[k] <= prod_next[k];
				diff_q[k] <= prod_all[k] - prod_all[k+1];
			end
		end
	end

	// hold off queries while the products settle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= '0;
		end else if (wr_en) begin
			settle_q <= plnb_pkg::SETTLE_W'(plnb_pkg::SETTLE_CYCLES);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - plnb_pkg::SETTLE_W'(1);
		end
	end

	assign busy     = (settle_q != '0);
	assign cfg.rank = rank_eff;
	assign cfg.prod = prod_all;
	assign cfg.diff = diff_q;

endmodule

// ===== design/plnb_cell.sv =====
// one restoring remainder cell, subtracts the axis block size shifted by SHIFT
module plnb_cell #(
	parameter int SHIFT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  plnb_pkg::lat_cfg_t  cfg,
	input  plnb_pkg::item_t     in_item,
	output plnb_pkg::item_t     out_item
);

	localparam int WIDE_W = plnb_pkg::PROD_W + plnb_pkg::SITE_W;

	logic [WIDE_W-1:0]           msh;
	logic                        take;
	logic [plnb_pkg::SITE_W-1:0] rem_next;
	plnb_pkg::item_t             item_q;

	// block size of the chosen axis, shifted into this cell's bit position
	always_comb begin
		msh      = WIDE_W'(cfg.prod[in_item.axis]) << SHIFT;
		take     = (msh[WIDE_W-1:plnb_pkg::SITE_W] == '0) &&
		           (msh[plnb_pkg::SITE_W-1:0] <= in_item.rem);
		rem_next = take ? (in_item.rem - msh[plnb_pkg::SITE_W-1:0]) : in_item.rem;
	end

	// stage register, only the valid bit is reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q.valid <= 1'b0;
		end else if (en) begin
			item_q.valid   <= in_item.valid;
			item_q.invalid <= in_item.invalid;
			item_q.back    <= in_item.back;
			item_q.axis    <= in_item.axis;
			item_q.site    <= in_item.site;
			item_q.rem     <= rem_next;
		end
	end

	assign out_item = item_q;

endmodule

// ===== design/plnb_wrap.sv =====
// turns the site's remainder within its axis block into the wrapped neighbor
module plnb_wrap (
	input  plnb_pkg::lat_cfg_t  cfg,
	input  plnb_pkg::item_t     item,
	output plnb_pkg::result_t   result
);

	localparam int CALC_W = plnb_pkg::PROD_W + 1;

	logic [plnb_pkg::RANK_W-1:0] up_axis;
	logic [CALC_W-1:0]           stride;
	logic [CALC_W-1:0]           span;
	logic [CALC_W-1:0]           rem;
	logic [CALC_W-1:0]           site;
	logic                        wrap;
	logic [CALC_W-1:0]           nb;

	always_comb begin
		up_axis = plnb_pkg::RANK_W'(item.axis) + plnb_pkg::RANK_W'(1);
		stride  = CALC_W'(cfg.prod[up_axis]);
		span    = CALC_W'(cfg.diff[item.axis]);
		rem     = CALC_W'(item.rem);
		site    = CALC_W'(item.site);
		// backward wraps at coordinate zero, forward at the last coordinate
		if (item.back) begin
			wrap = (rem < stride);
			nb   = wrap ? (site + span) : (site - stride);
		end else begin
			wrap = (rem >= span);
			nb   = wrap ? (site - span) : (site + stride);
		end
		result.invalid  = item.invalid;
		result.neighbor = item.invalid ? '0 : nb[plnb_pkg::SITE_W-1:0];
	end

endmodule

// ===== design/periodic_lattice_neighbor_core.sv =====
// top level of the periodic lattice neighbor index core
//
//  channel  dir  handshake                    content
//  s_axis   in   s_axis_tvalid/s_axis_tready  query word: site, axis, direction
//  m_axis   out  m_axis_tvalid/m_axis_tready  neighbor index and invalid flag
//  cfg      in   cfg_valid/cfg_ready          register index and write data
//
// one query word per cycle while s_axis_tready is high; the path is the entry register, 32
// remainder cells (one quotient bit each) and the output register
// a register write holds s_axis_tready low while the per-axis extent
// products ripple through their multipliers
// reset leaves rank 1 and every extent 1, with the products already valid
// a stalled output fills one skid word, then the whole cell row freezes
module periodic_lattice_neighbor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] site_index
	input  logic [2:0]  s_axis_tuser,   // [1:0] axis_select, [2] step_backward
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] neighbor_index
	output logic [0:0]  m_axis_tuser,   // [0] query_invalid
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int CELLS = plnb_pkg::SITE_W;

	plnb_pkg::lat_cfg_t  cfg;
	logic                busy;
	logic                en;
	logic                in_take;
	logic                entry_invalid;
	plnb_pkg::item_t     entry_s1;
	plnb_pkg::item_t     chain [CELLS+1];
	plnb_pkg::result_t   result;
	logic                exit_valid;
	logic                out_valid_q;
	plnb_pkg::result_t   out_q;
	logic                skid_valid_q;
	plnb_pkg::result_t   skid_q;

	assign cfg_ready = 1'b1;

	plnb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.busy     (busy)
	);

	// the cell row moves whenever the skid word is free
	assign en            = !skid_valid_q;
	assign s_axis_tready = en && !busy;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// query is rejected for an axis beyond rank or a site beyond the volume
	assign entry_invalid =
		(plnb_pkg::RANK_W'(s_axis_tuser[1:0]) >= cfg.rank) ||
		(plnb_pkg::PROD_W'(s_axis_tdata) >= cfg.prod[0]);

	// entry register, only the valid bit is reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_s1.valid <= 1'b0;
		end else if (en) begin
			entry_s1.valid   <= in_take;
			entry_s1.invalid <= entry_invalid;
			entry_s1.back    <= s_axis_tuser[2];
			entry_s1.axis    <= s_axis_tuser[1:0];
			entry_s1.site    <= s_axis_tdata;
			entry_s1.rem     <= s_axis_tdata;
		end
	end

	assign chain[0] = entry_s1;

	// remainder cells, most significant quotient bit first
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		plnb_cell #(
			.SHIFT (CELLS - 1 - i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.cfg      (cfg),
			.in_item  (chain[i]),
			.out_item (chain[i+1])
		);
	end

	plnb_wrap u_wrap (
		.cfg    (cfg),
		.item   (chain[CELLS]),
		.result (result)
	);

	assign exit_valid = en && chain[CELLS].valid;

	// output register with one skid word behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= exit_valid;
			end
		end else if (exit_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			out_q <= skid_valid_q ? skid_q : result;
		end else if (exit_valid) begin
			skid_q <= result;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_q.neighbor;
	assign m_axis_tuser[0] = out_q.invalid;

	// skid word only fills behind a waiting output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held without an output word");

	// a register write blocks queries on the next cycle
	a_write_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> !s_axis_tready)
		else $error("query accepted right after a register write");

	// rejected queries always report index zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
		else $error("invalid query with nonzero neighbor index");

	// a full skid word freezes the cell row
	a_skid_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> $stable(chain[CELLS]))
		else $error("cell row moved while skid word was full");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the periodic lattice neighbor core
module testbench;

	localparam int CLK_HIGH_NS = 6;
	localparam int CLK_LOW_NS = 6;
	localparam int RESET_CYCLES = 4;
	localparam int DRAIN_CYCLES = 48;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int HOLD_QUERIES = 200;
	localparam int QUERIES_PER_LATTICE = 128;
	localparam int LATTICES_PER_PHASE = 3;
	localparam int IDLE_PHASES = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	localparam int UNUSED_REG_LO = plnb_pkg::REG_EXT3 + 1;
	localparam int UNUSED_REG_HI = 2**plnb_pkg::CFG_IDX_W - 1;
	localparam int EXT_MAX = 2**plnb_pkg::EXT_W - 1;
	localparam int RANK_FIELD_MAX = 2**plnb_pkg::RANK_W - 1;

	typedef struct packed {
		logic [plnb_pkg::SITE_W-1:0] site;
		logic [plnb_pkg::AXIS_W-1:0] axis;
		logic                        back;
	} query_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [8:0]  cfg_data = '0;

	// lattice registers as the block should hold them
	logic [plnb_pkg::RANK_W-1:0] lat_rank_q = 3'd1;
	logic [plnb_pkg::EXT_W-1:0]  lat_ext_q [plnb_pkg::MAX_RANK] = '{default: 9'd1};

	query_t            queued_queries [$];
	plnb_pkg::result_t pending_neighbors [$];

	logic query_taken = 1'b0;
	logic cfg_taken = 1'b0;
	logic sink_hold = 1'b0;
	int   src_idle_pct = 0;
	int   sink_stall_pct = 0;
	int   mismatch_count = 0;
	int   cycle_count = 0;
	event long_hold_go;

	periodic_lattice_neighbor_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	always begin
		#CLK_HIGH_NS clk = 1'b1;
		#CLK_LOW_NS clk = 1'b0;
	end

	// ranks above the maximum act as the maximum
	function automatic int unsigned eff_rank();
		return (lat_rank_q > plnb_pkg::MAX_RANK) ? plnb_pkg::MAX_RANK : lat_rank_q;
	endfunction

	function automatic longint unsigned lattice_volume();
		longint unsigned vol = 1;
		for (int j = 0; j < eff_rank(); j++)
			vol *= lat_ext_q[j];
		return vol;
	endfunction

	// wrapped neighbor of one query under the current lattice
	function automatic plnb_pkg::result_t predict_neighbor(input query_t q);
		plnb_pkg::result_t r;
		longint unsigned stride, n, c, nc, nb;
		r.invalid = 1'b1;
		r.neighbor = '0;
		if (q.axis < eff_rank() && q.site < lattice_volume()) begin
			stride = 1;
			for (int j = eff_rank() - 1; j > q.axis; j--)
				stride *= lat_ext_q[j];
			n = lat_ext_q[q.axis];
			c = (q.site / stride) % n;
			if (q.back)
				nc = (c == 0) ? n - 1 : c - 1;
			else
				nc = (c + 1 == n) ? 0 : c + 1;
			nb = q.site - c * stride + nc * stride;
			r.invalid = 1'b0;
			r.neighbor = 32'(nb);
		end
		return r;
	endfunction

	function automatic void flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%s: expected %0h, got %0h", what, want, got);
	endfunction

	// mostly in-volume sites built from edge or random coordinates, some out of range
	function automatic query_t make_query();
		query_t q;
		longint unsigned site, n, c;
		int pick;
		site = 0;
		pick = $urandom_range(99);
		if (pick < 72) begin
			for (int j = 0; j < eff_rank(); j++) begin
				n = lat_ext_q[j];
				case ($urandom_range(3))
					0: c = 0;
					1: c = (n == 0) ? 0 : n - 1;
					default: c = (n == 0) ? 0 : $urandom_range(0, 32'(n - 1));
				endcase
				site = site * n + c;
			end
		end else if (pick < 80) begin
			site = lattice_volume();
		end else if (pick < 86) begin
			site = lattice_volume() - 1;
		end else if (pick < 94) begin
			site = $urandom;
		end else begin
			site = 32'hFFFF_FFFF;
		end
		q.site = 32'(site);
		if (eff_rank() != 0 && $urandom_range(99) < 85)
			q.axis = plnb_pkg::AXIS_W'($urandom_range(0, eff_rank() - 1));
		else
			q.axis = plnb_pkg::AXIS_W'($urandom);
		q.back = 1'($urandom);
		return q;
	endfunction

	task automatic push_query(input logic [31:0] site, input int axis, input bit back);
		query_t q;
		q.site = site;
		q.axis = plnb_pkg::AXIS_W'(axis);
		q.back = back;
		queued_queries.push_back(q);
	endtask

	// one register write, held until the handshake
	task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	// sender pauses until every word has come back and the pipe is empty
	task automatic wait_drained();
		while (queued_queries.size() != 0 || s_axis_tvalid || pending_neighbors.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// lattice shapes, extremes first, then random ones
	task automatic apply_lattice(input int k);
		logic [plnb_pkg::RANK_W-1:0] rk;
		logic [plnb_pkg::EXT_W-1:0]  ext [plnb_pkg::MAX_RANK];
		rk = plnb_pkg::RANK_W'(plnb_pkg::MAX_RANK);
		ext = '{default: 9'd1};
		case (k)
			// plain ring
			0: begin rk = 3'd1; ext[0] = 9'd256; end
			1: begin rk = 3'd2; ext[0] = 9'd16; ext[1] = 9'd16; end
			// unit extent on the middle axis
			2: begin rk = 3'd3; ext = '{9'd5, 9'd1, 9'd7, 9'd1}; end
			// volume of exactly 2^32
			3: ext = '{default: 9'd256};
			// extents past 256, volume beyond the index range
			4: ext = '{default: 9'd511};
			// no axis in use
			5: begin rk = 3'd0; ext = '{default: 9'd3}; end
			// rank saturates at the maximum
			6: begin rk = 3'd7; ext = '{9'd2, 9'd3, 9'd4, 9'd5}; end
			// empty lattice
			7: begin rk = 3'd2; ext = '{9'd6, 9'd0, 9'd4, 9'd4}; end
			// every extent one
			8: ;
			9: begin
				rk = plnb_pkg::RANK_W'($urandom_range(1, plnb_pkg::MAX_RANK));
				foreach (ext[j]) ext[j] = plnb_pkg::EXT_W'($urandom_range(1, 12));
			end
			10: begin
				rk = plnb_pkg::RANK_W'($urandom_range(0, RANK_FIELD_MAX));
				foreach (ext[j]) ext[j] = plnb_pkg::EXT_W'($urandom_range(0, EXT_MAX));
			end
			default: begin rk = 3'd3; ext = '{9'd2, 9'd2, 9'd2, 9'd1}; end
		endcase
		// writes past the register list must be ignored
		write_reg(plnb_pkg::CFG_IDX_W'($urandom_range(UNUSED_REG_LO, UNUSED_REG_HI)),
			plnb_pkg::EXT_W'($urandom));
		write_reg(plnb_pkg::REG_RANK,
			{(plnb_pkg::EXT_W-plnb_pkg::RANK_W)'($urandom), rk});
		foreach (ext[j]) write_reg(plnb_pkg::CFG_IDX_W'(plnb_pkg::REG_EXT0 + j), ext[j]);
	endtask

	// query driver, one word per handshake
	always @(negedge clk) begin : query_driver
		query_t q;
		if (!s_axis_tvalid || query_taken) begin
			if (arst_n && queued_queries.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				q = queued_queries.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= q.site;
				s_axis_tuser <= {q.back, q.axis};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result sink with random stalls and the long hold-off
	always @(negedge clk)
		m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);

	always begin : long_hold
		@(long_hold_go);
		sink_hold = 1'b1;
		repeat (LONG_HOLD_CYCLES) @(posedge clk);
		sink_hold = 1'b0;
	end

	// monitor: tracks registers, predicts on accept, checks each result word
	always @(posedge clk) begin : monitor
		plnb_pkg::result_t want;
		if (!arst_n) begin
			query_taken <= 1'b0;
			cfg_taken <= 1'b0;
			lat_rank_q <= 3'd1;
			foreach (lat_ext_q[j]) lat_ext_q[j] <= 9'd1;
		end else begin
			query_taken <= s_axis_tvalid && s_axis_tready;
			cfg_taken <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					plnb_pkg::REG_RANK: lat_rank_q <= cfg_data[plnb_pkg::RANK_W-1:0];
					plnb_pkg::REG_EXT0: lat_ext_q[0] <= cfg_data;
					plnb_pkg::REG_EXT1: lat_ext_q[1] <= cfg_data;
					plnb_pkg::REG_EXT2: lat_ext_q[2] <= cfg_data;
					plnb_pkg::REG_EXT3: lat_ext_q[3] <= cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				pending_neighbors.push_back(predict_neighbor(
					{s_axis_tdata, s_axis_tuser[1:0], s_axis_tuser[2]}));
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_neighbors.size() == 0) begin
					flag_mismatch("unexpected word", '0, m_axis_tdata);
				end else begin
					want = pending_neighbors.pop_front();
					if (m_axis_tdata !== want.neighbor)
						flag_mismatch("neighbor_index", want.neighbor, m_axis_tdata);
					if (m_axis_tuser[0] !== want.invalid)
						flag_mismatch("query_invalid", 32'(want.invalid),
							32'(m_axis_tuser[0]));
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("periodic_lattice_neighbor_core: mismatch");
			$finish;
		end
	end

	// stimulus sequence
	initial begin : stimulus
		int src_pct [IDLE_PHASES];
		int sink_pct [IDLE_PHASES];
		src_pct = '{0, 64, 0, 24};
		sink_pct = '{0, 0, 64, 24};
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset lattice: a single site on one axis
		push_query(32'd0, 0, 1'b0);
		push_query(32'd0, 0, 1'b1);
		push_query(32'd1, 0, 1'b0);
		push_query(32'd0, 1, 1'b0);
		push_query(32'hFFFF_FFFF, 3, 1'b1);
		wait_drained();

		// 5 x 1 x 7 lattice: wrap at both corners on every axis
		apply_lattice(2);
		for (int a = 0; a < 3; a++) begin
			push_query(32'd0, a, 1'b0);
			push_query(32'd0, a, 1'b1);
			push_query(32'd34, a, 1'b0);
			push_query(32'd34, a, 1'b1);
		end
		push_query(32'd3, 3, 1'b0);
		push_query(32'd35, 0, 1'b0);
		wait_drained();

		// receiver holds off while the sender keeps offering
		apply_lattice(1);
		repeat (HOLD_QUERIES) queued_queries.push_back(make_query());
		->long_hold_go;
		wait_drained();

		// random queries over all lattice shapes and idle patterns
		for (int p = 0; p < IDLE_PHASES; p++) begin
			src_idle_pct = src_pct[p];
			sink_stall_pct = sink_pct[p];
			for (int s = 0; s < LATTICES_PER_PHASE; s++) begin
				apply_lattice(p * LATTICES_PER_PHASE + s);
				repeat (QUERIES_PER_LATTICE) queued_queries.push_back(make_query());
				wait_drained();
			end
		end

		if (mismatch_count == 0)
			$display("periodic_lattice_neighbor_core: match");
		else
			$display("periodic_lattice_neighbor_core: mismatch");
		$finish;
	end

endmodule

// ===== periodic_lattice_neighbor_core.f =====
design/plnb_pkg.sv
design/plnb_cfg.sv
design/plnb_cell.sv
design/plnb_wrap.sv
design/periodic_lattice_neighbor_core.sv
tb/testbench.sv
